/* sv/hx_pkg.sv */
// ----------------------------------------------------------------------------
// hx_pkg
// Shared constants, types and helpers of the harmonic exciter: sizes,
// datapath operation codes, the tanh table and the rounding helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package hx_pkg;

   localparam int NUM_CHANNELS    = 2;
   localparam int TANH_TABLE_SIZE = 256;

   localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int IDX_W  = $clog2(TANH_TABLE_SIZE + 1);
   localparam int ADDR_W = 5;

   // register indexes on the csr port
   localparam logic [2:0] REG_CUTOFF  = 3'd0;
   localparam logic [2:0] REG_DAMPING = 3'd1;
   localparam logic [2:0] REG_NORM    = 3'd2;
   localparam logic [2:0] REG_DRIVE   = 3'd3;
   localparam logic [2:0] REG_RECIP   = 3'd4;
   localparam logic [2:0] REG_WET     = 3'd5;
   localparam logic [2:0] REG_OUTGAIN = 3'd6;

   typedef struct packed {
      logic [17:0] cutoff_coef;
      logic [17:0] damping_sum;
      logic [16:0] norm_coef;
      logic [15:0] drive;
      logic [16:0] drive_recip;
      logic [16:0] wet_gain;
      logic [17:0] out_gain;
   } cfg_type;

   typedef enum logic [3:0] {
      OP_DAMP,
      OP_NORM,
      OP_GH,
      OP_GB,
      OP_DRV,
      OP_IDX,
      OP_INT,
      OP_REC,
      OP_WET,
      OP_OUT
   } op_type;

   typedef struct packed {
      logic   load;
      logic   mul;
      logic   wb;
      logic   rom;
      op_type op;
   } cmd_type;

   typedef logic [31:0] tanh_rom_type [0:TANH_TABLE_SIZE];

   // shift and subtract quotient, only used while the table is worked out
   function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
      logic [63:0] quo;
      logic [63:0] rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // tanh(k*step) in Q1.30 by the tanh addition formula, worked out at elaboration
   function automatic tanh_rom_type build_tanh();
      tanh_rom_type     rom;
      longint unsigned  one;
      longint unsigned  half;
      longint unsigned  d;
      longint unsigned  d2;
      longint unsigned  d3;
      longint unsigned  d5;
      longint unsigned  d7;
      longint unsigned  t;
      longint unsigned  cur;
      longint unsigned  num;
      longint unsigned  den;
      one  = 64'd1 << 30;
      half = one >> 1;
      d    = div_u64((64'd4 << 30) + (64'(TANH_TABLE_SIZE) >> 1), 64'(TANH_TABLE_SIZE));
      d2   = (d * d + half) >> 30;
      d3   = (d2 * d + half) >> 30;
      d5   = (d3 * d2 + half) >> 30;
      d7   = (d5 * d2 + half) >> 30;
      t    = d - div_u64(d3 + 1, 64'd3) + div_u64(2 * d5 + 7, 64'd15)
             - div_u64(17 * d7 + 157, 64'd315);
      cur  = 0;
      rom[0] = 32'd0;
      for (int i = 1; i <= TANH_TABLE_SIZE; i++) begin
         num = (cur + t) << 30;
         den = one + ((cur * t + half) >> 30);
         cur = div_u64(num + (den >> 1), den);
         rom[i] = cur[31:0];
      end
      return rom;
   endfunction

   localparam tanh_rom_type TANH_ROM = build_tanh();

   // add half an lsb, then floor shift
   function automatic logic signed [63:0] rnd_shift(logic signed [63:0] v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic logic signed [31:0] sat32(logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

endpackage

`default_nettype wire

/* sv/hx_regs.sv */
// ----------------------------------------------------------------------------
// hx_regs
// Configuration register file behind the csr port.
// ----------------------------------------------------------------------------
`default_nettype none

module hx_regs (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  psel,
   input  wire                  penable,
   input  wire                  pwrite,
   input  wire [hx_pkg::ADDR_W-1:0] paddr,
   input  wire [31:0]           pwdata,
   output logic [31:0]          prdata,
   output logic                 pready,
   output hx_pkg::cfg_type      cfg
);
   import hx_pkg::*;

   cfg_type     cfg_ff;
   logic        wr_en;
   logic [2:0]  reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[4:2];
   assign cfg     = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cutoff_coef <= 18'd17990;
         cfg_ff.damping_sum <= 18'd110672;
         cfg_ff.norm_coef   <= 17'd46000;
         cfg_ff.drive       <= 16'd17203;
         cfg_ff.drive_recip <= 17'd15603;
         cfg_ff.wet_gain    <= 17'd13107;
         cfg_ff.out_gain    <= 18'd65536;
      end else if (wr_en) begin
         case (reg_idx)
            REG_CUTOFF:  cfg_ff.cutoff_coef <= pwdata[17:0];
            REG_DAMPING: cfg_ff.damping_sum <= pwdata[17:0];
            REG_NORM:    cfg_ff.norm_coef   <= pwdata[16:0];
            REG_DRIVE:   cfg_ff.drive       <= pwdata[15:0];
            REG_RECIP:   cfg_ff.drive_recip <= pwdata[16:0];
            REG_WET:     cfg_ff.wet_gain    <= pwdata[16:0];
            REG_OUTGAIN: cfg_ff.out_gain    <= pwdata[17:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_CUTOFF:  prdata = {14'd0, cfg_ff.cutoff_coef};
         REG_DAMPING: prdata = {14'd0, cfg_ff.damping_sum};
         REG_NORM:    prdata = {15'd0, cfg_ff.norm_coef};
         REG_DRIVE:   prdata = {16'd0, cfg_ff.drive};
         REG_RECIP:   prdata = {15'd0, cfg_ff.drive_recip};
         REG_WET:     prdata = {15'd0, cfg_ff.wet_gain};
         REG_OUTGAIN: prdata = {14'd0, cfg_ff.out_gain};
         default:     prdata = 32'd0;
      endcase
   end

endmodule

`default_nettype wire

/* sv/hx_ctrl.sv */
// ----------------------------------------------------------------------------
// hx_ctrl
// Sequencer: steps the datapath through its multiply, write-back and table
// read ops and runs both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module hx_ctrl (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  wire              rsp_stall,
   output hx_pkg::cmd_type  cmd
);
   import hx_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WB,
      ST_ROM
   } state_type;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd.load     = 1'b0;
      cmd.mul      = 1'b0;
      cmd.wb       = 1'b0;
      cmd.rom      = 1'b0;
      cmd.op       = op_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               op_in    = OP_DAMP;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            cmd.mul  = 1'b1;
            state_in = ST_WB;
         end
         ST_WB: begin
            if (op_ff == OP_OUT) begin
               // hold the product until the output register is free
               if (out_free) begin
                  cmd.wb       = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               cmd.wb   = 1'b1;
               op_in    = op_type'(4'(op_ff) + 4'd1);
               state_in = (op_ff == OP_IDX) ? ST_ROM : ST_ISSUE;
            end
         end
         ST_ROM: begin
            cmd.rom  = 1'b1;
            state_in = ST_ISSUE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_DAMP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

/* sv/hx_datapath.sv */
// ----------------------------------------------------------------------------
// hx_datapath
// One shared signed multiplier with a product register, the filter state
// per channel, the tanh table and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hx_datapath (
   input  wire                 clock,
   input  wire                 reset,
   input  hx_pkg::cmd_type     cmd,
   input  hx_pkg::cfg_type     cfg,
   input  wire signed [23:0]   req_sample_in,
   input  wire                 req_chan,
   output logic signed [23:0]  rsp_sample_out
);
   import hx_pkg::*;

   localparam logic signed [63:0] TANH_LIMIT = 64'sd4 <<< 24;

   logic signed [31:0] integ_one_ff [NUM_CHANNELS];
   logic signed [31:0] integ_two_ff [NUM_CHANNELS];

   logic signed [24:0]  x_ff;
   logic [CH_W-1:0]     ch_ff;
   logic signed [31:0]  s1_ff, s2_ff;
   logic signed [35:0]  t_ff;
   logic signed [31:0]  hp_ff, bp_ff;
   logic                neg_ff;
   logic [35:0]         a_ff;
   logic                ovr_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic [25:0]         frac_ff;
   logic [31:0]         t0_ff, t1_ff;
   logic signed [26:0]  e_ff;
   logic signed [27:0]  y_ff;
   logic signed [62:0]  p_ff;
   logic signed [23:0]  out_ff;

   logic [CH_W:0]       ch_ext;
   logic [CH_W-1:0]     ch_sel;
   logic signed [35:0]  mul_a;
   logic signed [26:0]  mul_b;
   logic signed [63:0]  pr;
   logic signed [63:0]  gh, bp, gb, lp, u, mag, v, o, idx_full;
   logic signed [31:0]  s1_new, s2_new;

   assign rsp_sample_out = out_ff;

   // channel taken modulo the channel count
   always_comb begin
      ch_ext = (CH_W + 1)'(req_chan);
      if (ch_ext >= (CH_W + 1)'(NUM_CHANNELS)) begin
         ch_ext = ch_ext - (CH_W + 1)'(NUM_CHANNELS);
      end
      ch_sel = ch_ext[CH_W-1:0];
   end

   always_comb begin
      case (cmd.op)
         OP_DAMP: begin
            mul_a = 36'(s1_ff);
            mul_b = $signed({9'd0, cfg.damping_sum});
         end
         OP_NORM: begin
            mul_a = t_ff;
            mul_b = $signed({10'd0, cfg.norm_coef});
         end
         OP_GH: begin
            mul_a = 36'(hp_ff);
            mul_b = $signed({9'd0, cfg.cutoff_coef});
         end
         OP_GB: begin
            mul_a = 36'(bp_ff);
            mul_b = $signed({9'd0, cfg.cutoff_coef});
         end
         OP_DRV: begin
            mul_a = 36'(hp_ff);
            mul_b = $signed({11'd0, cfg.drive});
         end
         OP_IDX: begin
            mul_a = $signed(a_ff);
            mul_b = 27'(TANH_TABLE_SIZE);
         end
         OP_INT: begin
            mul_a = 36'($signed({1'b0, t1_ff}) - $signed({1'b0, t0_ff}));
            mul_b = $signed({1'b0, frac_ff});
         end
         OP_REC: begin
            mul_a = 36'(e_ff);
            mul_b = $signed({10'd0, cfg.drive_recip});
         end
         OP_WET: begin
            mul_a = 36'(e_ff);
            mul_b = $signed({10'd0, cfg.wet_gain});
         end
         OP_OUT: begin
            mul_a = 36'(y_ff);
            mul_b = $signed({9'd0, cfg.out_gain});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // write-back arithmetic on the registered product
   always_comb begin
      pr       = 64'(p_ff);
      gh       = rnd_shift(pr, 16);
      bp       = 64'(sat32(gh + 64'(s1_ff)));
      s1_new   = sat32(gh + bp);
      gb       = rnd_shift(pr, 16);
      lp       = 64'(sat32(gb + 64'(s2_ff)));
      s2_new   = sat32(gb + lp);
      u        = rnd_shift(pr, 12);
      idx_full = pr >>> 26;
      v        = 64'($signed({1'b0, t0_ff})) + rnd_shift(pr, 26);
      if (ovr_ff) begin
         mag = rnd_shift(64'($signed({1'b0, TANH_ROM[TANH_TABLE_SIZE]})), 6);
      end else begin
         mag = rnd_shift(v, 6);
      end
      o = rnd_shift(pr, 17);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            integ_one_ff[i] <= '0;
            integ_two_ff[i] <= '0;
         end
      end else if (cmd.wb && cmd.op == OP_GH) begin
         integ_one_ff[ch_ff] <= s1_new;
      end else if (cmd.wb && cmd.op == OP_GB) begin
         integ_two_ff[ch_ff] <= s2_new;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff  <= {req_sample_in, 1'b0};
         ch_ff <= ch_sel;
         s1_ff <= integ_one_ff[ch_sel];
         s2_ff <= integ_two_ff[ch_sel];
      end
      if (cmd.mul) begin
         p_ff <= mul_a * mul_b;
      end
      if (cmd.rom) begin
         t0_ff <= TANH_ROM[idx_ff];
         t1_ff <= TANH_ROM[idx_ff + IDX_W'(1)];
      end
      if (cmd.wb) begin
         case (cmd.op)
            OP_DAMP: t_ff <= 36'(64'(x_ff) - rnd_shift(pr, 16) - 64'(s2_ff));
            OP_NORM: hp_ff <= sat32(rnd_shift(pr, 16));
            OP_GH:   bp_ff <= bp[31:0];
            OP_GB: ;
            OP_DRV: begin
               neg_ff <= u[63];
               a_ff   <= u[63] ? 36'(-u) : u[35:0];
               ovr_ff <= (u[63] ? -u : u) >= TANH_LIMIT;
            end
            OP_IDX: begin
               frac_ff <= p_ff[25:0];
               if (ovr_ff || idx_full >= 64'(TANH_TABLE_SIZE)) begin
                  ovr_ff <= 1'b1;
                  idx_ff <= IDX_W'(TANH_TABLE_SIZE - 1);
               end else begin
                  idx_ff <= idx_full[IDX_W-1:0];
               end
            end
            OP_INT:  e_ff <= neg_ff ? 27'(-mag) : mag[26:0];
            OP_REC:  e_ff <= 27'(rnd_shift(pr, 16));
            OP_WET:  y_ff <= 28'(64'(x_ff) + rnd_shift(pr, 16));
            OP_OUT: begin
               if (o > 64'sd8388607) begin
                  out_ff <= 24'sh7FFFFF;
               end else if (o < -64'sd8388608) begin
                  out_ff <= 24'sh800000;
               end else begin
                  out_ff <= o[23:0];
               end
            end
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire

/* sv/harmonic_exciter_unit.sv */
// ----------------------------------------------------------------------------
// harmonic_exciter_unit
// Per-channel state-variable highpass exciter with tanh shaping.
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_stall  req_sample_in, req_chan
//   rsp       out        rsp_valid/rsp_stall  rsp_sample_out
//   csr       in/out     psel/penable/pready  paddr, pwdata, prdata
//
// Between accept and result an item runs ten multiply/write-back
// pairs on the one shared multiplier plus a table read.
// The next beat is accepted in the cycle after the result is loaded, even
// while that result still waits on rsp_stall.
// Synchronous reset clears the filter state and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module harmonic_exciter_unit (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_stall,
   input  wire signed [23:0]        req_sample_in,
   input  wire                      req_chan,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output logic signed [23:0]       rsp_sample_out,
   input  wire                      psel,
   input  wire                      penable,
   input  wire                      pwrite,
   input  wire [hx_pkg::ADDR_W-1:0] paddr,
   input  wire [31:0]               pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);
   import hx_pkg::*;

   cfg_type cfg;
   cmd_type cmd;

   hx_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   hx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   hx_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .cfg            (cfg),
      .req_sample_in  (req_sample_in),
      .req_chan       (req_chan),
      .rsp_sample_out (rsp_sample_out)
   );

endmodule

`default_nettype wire
